// ----- rtl/utn_pkg.sv -----
// ============================================================================
// utn_pkg - shared types and constants of the UTF-16LE name transcoder
// Beat payloads, the work entry passed from the front end to the back end,
// status codes and the fixed constants of the UTF-16 and UTF-8 encodings.
// ============================================================================
`default_nettype none

package utn_pkg;

    // Status codes carried on the closing beat of a name.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SURR  = 3'd1;
    localparam logic [2:0] ST_FORBIDDEN = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_DOT_NAME  = 3'd4;

    localparam int DEF_MAX_UNITS = 255;

    // Work queue between front end and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    localparam logic [20:0] CP_NUL       = 21'h00000;
    localparam logic [20:0] CP_SLASH     = 21'h0002F;
    localparam logic [20:0] CP_BACKSLASH = 21'h0005C;
    localparam logic [7:0]  CH_DOT       = 8'h2E;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        final_unit;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       name_end;
        logic [2:0] status;
    } t_out_item;

    // One unit's worth of results: zero to four bytes, then an optional
    // status beat when the unit closes the name.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
        logic            fin;
        logic [2:0]      status;
    } t_work;

    typedef struct packed {
        logic  push;
        t_work entry;
    } t_push;

endpackage

`default_nettype wire

// ----- rtl/utn_front.sv -----
// ============================================================================
// utn_front - front end: surrogate pairing, checks and UTF-8 encoding
// Accepts a code unit a cycle unless stalled, keeps per-name state, pushes a
// work entry of the encoded bytes and, on the final unit, the name status.
// ============================================================================
`default_nettype none

module utn_front #(
    parameter int MAX_UNITS = utn_pkg::DEF_MAX_UNITS
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  utn_pkg::t_in_item i_in_item,
    input  wire              i_q_full,
    output logic             o_in_stall,
    output utn_pkg::t_push   o_push
);

    logic [9:0] r_pend_bits, n_pend_bits;
    logic       r_pend_valid, n_pend_valid;
    logic [7:0] r_units, n_units;
    logic [2:0] r_err, n_err;
    logic [1:0] r_bytes_cap, n_bytes_cap;
    logic       r_dots, n_dots;

    logic       accept;
    logic [2:0] nb;
    logic [3:0][7:0] bytes;
    logic [2:0] status;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        logic        is_high;
        logic        is_low;
        logic        have_cp;
        logic [20:0] cp;
        logic [2:0]  cap_sum;
        logic [15:0] c;

        c       = i_in_item.code_unit;
        is_high = (c >= utn_pkg::HIGH_FIRST) && (c <= utn_pkg::HIGH_LAST);
        is_low  = (c >= utn_pkg::LOW_FIRST) && (c <= utn_pkg::LOW_LAST);
        have_cp = 1'b0;
        cp      = '0;
        nb      = '0;
        bytes   = '0;

        n_pend_bits  = r_pend_bits;
        n_pend_valid = r_pend_valid;
        n_err        = r_err;

        if (r_units >= 8'(MAX_UNITS)) begin
            // Length is judged before content and overrides earlier errors.
            n_err        = utn_pkg::ST_TOO_LONG;
            n_pend_valid = 1'b0;
            n_pend_bits  = '0;
        end else if (r_err == utn_pkg::ST_OK) begin
            if (r_pend_valid) begin
                n_pend_valid = 1'b0;
                if (!is_low) begin
                    n_err = utn_pkg::ST_BAD_SURR;
                end else begin
                    cp          = utn_pkg::SUPP_BASE + {1'b0, r_pend_bits, c[9:0]};
                    have_cp     = 1'b1;
                    n_pend_bits = '0;
                end
            end else if (is_high) begin
                if (i_in_item.final_unit) begin
                    n_err = utn_pkg::ST_BAD_SURR;
                end else begin
                    n_pend_bits  = c[9:0];
                    n_pend_valid = 1'b1;
                end
            end else if (is_low) begin
                n_err = utn_pkg::ST_BAD_SURR;
            end else begin
                cp      = {5'd0, c};
                have_cp = 1'b1;
            end

            if (have_cp) begin
                if (cp == utn_pkg::CP_NUL || cp == utn_pkg::CP_SLASH ||
                    cp == utn_pkg::CP_BACKSLASH) begin
                    n_err = utn_pkg::ST_FORBIDDEN;
                end else if (cp < 21'h80) begin
                    nb       = 3'd1;
                    bytes[0] = cp[7:0];
                end else if (cp < 21'h800) begin
                    nb       = 3'd2;
                    bytes[0] = utn_pkg::LEAD2 | {3'd0, cp[10:6]};
                    bytes[1] = utn_pkg::CONT | {2'd0, cp[5:0]};
                end else if (cp < utn_pkg::SUPP_BASE) begin
                    nb       = 3'd3;
                    bytes[0] = utn_pkg::LEAD3 | {4'd0, cp[15:12]};
                    bytes[1] = utn_pkg::CONT | {2'd0, cp[11:6]};
                    bytes[2] = utn_pkg::CONT | {2'd0, cp[5:0]};
                end else begin
                    nb       = 3'd4;
                    bytes[0] = utn_pkg::LEAD4 | {5'd0, cp[20:18]};
                    bytes[1] = utn_pkg::CONT | {2'd0, cp[17:12]};
                    bytes[2] = utn_pkg::CONT | {2'd0, cp[11:6]};
                    bytes[3] = utn_pkg::CONT | {2'd0, cp[5:0]};
                end
            end
        end

        n_units = (r_units == 8'hFF) ? r_units : r_units + 8'd1;

        cap_sum     = {1'b0, r_bytes_cap} + nb;
        n_bytes_cap = (cap_sum >= 3'd3) ? 2'd3 : cap_sum[1:0];

        // Only a single-byte character can be a dot.
        n_dots = r_dots;
        if (nb != 3'd0 && !(nb == 3'd1 && bytes[0] == utn_pkg::CH_DOT)) begin
            n_dots = 1'b0;
        end

        status = n_err;
        if (n_err == utn_pkg::ST_OK && n_dots &&
            (n_bytes_cap == 2'd1 || n_bytes_cap == 2'd2)) begin
            status = utn_pkg::ST_DOT_NAME;
        end
    end

    always_comb begin
        o_push.push         = accept && (nb != 3'd0 || i_in_item.final_unit);
        o_push.entry.bytes  = bytes;
        o_push.entry.nbytes = nb;
        o_push.entry.fin    = i_in_item.final_unit;
        o_push.entry.status = i_in_item.final_unit ? status : utn_pkg::ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits  <= '0;
            r_pend_valid <= 1'b0;
            r_units      <= '0;
            r_err        <= utn_pkg::ST_OK;
            r_bytes_cap  <= '0;
            r_dots       <= 1'b1;
        end else if (accept) begin
            if (i_in_item.final_unit) begin
                r_pend_bits  <= '0;
                r_pend_valid <= 1'b0;
                r_units      <= '0;
                r_err        <= utn_pkg::ST_OK;
                r_bytes_cap  <= '0;
                r_dots       <= 1'b1;
            end else begin
                r_pend_bits  <= n_pend_bits;
                r_pend_valid <= n_pend_valid;
                r_units      <= n_units;
                r_err        <= n_err;
                r_bytes_cap  <= n_bytes_cap;
                r_dots       <= n_dots;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utn_queue.sv -----
// ============================================================================
// utn_queue - work queue between front end and back end
// A small register FIFO of work entries with an occupancy count.
// ============================================================================
`default_nettype none

module utn_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  utn_pkg::t_push  i_push,
    input  wire             i_pop,
    output logic            o_full,
    output logic            o_empty,
    output utn_pkg::t_work  o_head
);

    localparam int W = utn_pkg::QPTR_W;

    utn_pkg::t_work r_mem [utn_pkg::QUEUE_DEPTH];
    logic [W-1:0]   r_wr_ptr;
    logic [W-1:0]   r_rd_ptr;
    logic [W:0]     r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == (W+1)'(utn_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == W'(utn_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == W'(utn_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utn_back.sv -----
// ============================================================================
// utn_back - back end: serialises work entries into result beats
// Takes one entry at a time from the queue and sends its bytes, then the
// status beat if the entry closes a name, through an output register.
// ============================================================================
`default_nettype none

module utn_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_q_empty,
    input  utn_pkg::t_work    i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    output utn_pkg::t_out_item o_out_item,
    input  wire               i_out_stall
);

    utn_pkg::t_work    r_cur;
    logic              r_cur_valid;
    logic [2:0]        r_idx;
    logic              r_out_valid;
    utn_pkg::t_out_item r_out_item;
    utn_pkg::t_out_item n_out_item;

    logic       slot_free;
    logic       emit;
    logic       last;
    logic [2:0] count;

    assign count     = r_cur.nbytes + {2'd0, r_cur.fin};
    assign slot_free = !r_out_valid || !i_out_stall;
    assign emit      = r_cur_valid && slot_free;
    assign last      = emit && (r_idx == count - 3'd1);
    assign o_pop     = (!r_cur_valid || last) && !i_q_empty;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        if (r_idx < r_cur.nbytes) begin
            n_out_item.out_byte   = r_cur.bytes[r_idx[1:0]];
            n_out_item.byte_valid = 1'b1;
            n_out_item.name_end   = 1'b0;
            n_out_item.status     = utn_pkg::ST_OK;
        end else begin
            n_out_item.out_byte   = '0;
            n_out_item.byte_valid = 1'b0;
            n_out_item.name_end   = 1'b1;
            n_out_item.status     = r_cur.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_item <= n_out_item;
        end
        if (o_pop) begin
            r_cur <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur_valid <= 1'b1;
                r_idx       <= '0;
            end else if (last) begin
                r_cur_valid <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 3'd1;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (slot_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utf16le_name_to_utf8.sv -----
// ============================================================================
// utf16le_name_to_utf8 - UTF-16LE file name to UTF-8 transcoder
// Pairs surrogates, checks the name and emits UTF-8 bytes and a status beat.
// ============================================================================
// The block takes one code unit per beat and can accept a unit every cycle
// while its four-entry work queue has room. Each unit gives zero to four
// UTF-8 byte beats, and a final unit adds one status beat; the output sends
// one beat a cycle while it is not stalled, and a unit's result beats (one
// for ASCII, up to three for a basic-plane character, four for a surrogate
// pair, plus one at the end of a name) leave one after another. The sustained
// rate is set by that single-beat output. On a non-zero status the bytes
// already sent for the name are to be discarded.
`default_nettype none

module utf16le_name_to_utf8 #(
    parameter int MAX_UNITS = utn_pkg::DEF_MAX_UNITS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  utn_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output utn_pkg::t_out_item o_out_item,
    input  wire                i_out_stall
);

    utn_pkg::t_push push;
    utn_pkg::t_work head;
    logic           q_full;
    logic           q_empty;
    logic           pop;

    utn_front #(
        .MAX_UNITS(MAX_UNITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push)
    );

    utn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    utn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ----- rtl/utn_checker.sv -----
// ============================================================================
// utn_checker - port-level checks for the UTF-16LE name transcoder
// Watches the result channel for well-formed data and status beats.
// ============================================================================
`default_nettype none

module utn_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_out_valid,
    input utn_pkg::t_out_item i_out_item,
    input wire                i_out_stall
);

    // A stalled result beat stays in place unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_item))
        else $error("result beat changed while stalled");

    // Every beat is either a data byte or a closing status, never both.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_item.byte_valid != i_out_item.name_end))
        else $error("result beat is neither data nor status");

    // Data beats carry no status.
    a_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.byte_valid |-> i_out_item.status == utn_pkg::ST_OK)
        else $error("data beat carries a status");

    // Status beats carry a zero byte and a defined code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.name_end |->
            i_out_item.out_byte == 8'd0 && i_out_item.status <= utn_pkg::ST_DOT_NAME)
        else $error("malformed status beat");

endmodule

bind utf16le_name_to_utf8 utn_checker u_utn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
